[sv/pftr_pkg.sv]
// Shared constants, types and the glyph font table of the page frame buffer text renderer.
package pftr_pkg;

    // Frame store geometry.
    localparam int MAX_COLUMNS = 128;
    localparam int PAGE_COUNT  = 8;
    localparam int STORE_BYTES = MAX_COLUMNS * PAGE_COUNT;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int PANEL_ROWS  = 8 * PAGE_COUNT;
    localparam int COL_W       = $clog2(MAX_COLUMNS + 1);
    localparam int ROW_W       = $clog2(PANEL_ROWS + 1);
    localparam int PAGE_W      = 5;
    localparam int PROD_W      = PAGE_W + COL_W;
    localparam int SUM_W       = PROD_W + 1;

    // Glyph geometry and character mapping.
    localparam int FIRST_CODE    = 32;
    localparam int LAST_CODE     = 127;
    localparam int FALLBACK_CODE = 63;
    localparam int GLYPH_COLS    = 5;
    localparam int GLYPH_ROWS    = 8;
    localparam int ROM_GLYPHS    = 26;
    localparam int FONT_ENTRIES  = ROM_GLYPHS * GLYPH_COLS;
    localparam int FONT_IDX_W    = $clog2(FONT_ENTRIES);

    // Result of the pixel address unit.
    typedef struct packed {
        logic              hit;
        logic [ADDR_W-1:0] addr;
        logic [2:0]        bit_sel;
    } pix_t;

    // Write request into the frame store.
    typedef struct packed {
        logic              wr_en;
        logic              clear;
        logic [ADDR_W-1:0] addr;
        logic [2:0]        bit_sel;
        logic              on;
    } store_cmd_t;

    // Font columns, five per glyph, bit 0 is the top row.
    localparam logic [7:0] FONT_ROM [FONT_ENTRIES] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00,  8'h00, 8'h00, 8'h5F, 8'h00, 8'h00,
        8'h00, 8'h07, 8'h00, 8'h07, 8'h00,  8'h14, 8'h7F, 8'h14, 8'h7F, 8'h14,
        8'h24, 8'h2A, 8'h7F, 8'h2A, 8'h12,  8'h23, 8'h13, 8'h08, 8'h64, 8'h62,
        8'h36, 8'h49, 8'h55, 8'h22, 8'h50,  8'h00, 8'h05, 8'h03, 8'h00, 8'h00,
        8'h00, 8'h1C, 8'h22, 8'h41, 8'h00,  8'h00, 8'h41, 8'h22, 8'h1C, 8'h00,
        8'h14, 8'h08, 8'h3E, 8'h08, 8'h14,  8'h08, 8'h08, 8'h3E, 8'h08, 8'h08,
        8'h00, 8'h50, 8'h30, 8'h00, 8'h00,  8'h08, 8'h08, 8'h08, 8'h08, 8'h08,
        8'h00, 8'h60, 8'h60, 8'h00, 8'h00,  8'h20, 8'h10, 8'h08, 8'h04, 8'h02,
        8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E,  8'h00, 8'h42, 8'h7F, 8'h40, 8'h00,
        8'h42, 8'h61, 8'h51, 8'h49, 8'h46,  8'h21, 8'h41, 8'h45, 8'h4B, 8'h31,
        8'h18, 8'h14, 8'h12, 8'h7F, 8'h10,  8'h27, 8'h45, 8'h45, 8'h45, 8'h39,
        8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30,  8'h01, 8'h71, 8'h09, 8'h05, 8'h03,
        8'h36, 8'h49, 8'h49, 8'h49, 8'h36,  8'h06, 8'h49, 8'h49, 8'h29, 8'h1E
    };

    // Column of a glyph; glyphs beyond the table are blank.
    function automatic logic [7:0] font_column(input logic [6:0] idx, input logic [2:0] col);
        logic [FONT_IDX_W-1:0] pos;
        logic [7:0]            column;
        pos = FONT_IDX_W'(10'(idx) * 10'(GLYPH_COLS) + 10'(col));
        if (32'(idx) < ROM_GLYPHS)
        begin
            column = FONT_ROM[pos];
        end
        else
        begin
            column = 8'h00;
        end
        return column;
    endfunction

endpackage

[sv/page_framebuffer_text_renderer.sv]
// Top level of the page frame buffer text renderer: request sequencer, registers and ports.
//
// The block keeps a monochrome frame store organized in pages; each byte holds eight
// vertical pixels, bit 0 on top. Requests arrive on the s_ stream: s_tuser carries the
// operation (clear all, draw pixel, draw glyph, read byte) and s_tdata the operands.
// Only a read byte request produces a response, which leaves on the m_ stream.
// The panel size is set by the user through the cfg_ write port while the block is idle,
// not enforced by the block. Pixels at or beyond the active width or height are skipped.
//
// One request is worked on at a time and s_tready is low meanwhile. Every pixel goes
// through the single pixel address unit and a read-modify-write of the store, a
// store read step and then a write step; a glyph is 40 pixels. A read waits after
// its store read step until the output register is free. Clear all sweeps the store
// one byte per cycle, over all 1024 bytes.
// After reset the same sweep runs before s_tready rises; configuration writes are
// taken at any time.
// The response sits in an output register: a stalled receiver does not stop drawing
// requests, but a further read waits until the previous response has been taken.
module page_framebuffer_text_renderer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // pos_x, pos_y, pixel_on, glyph_code, read_address, zero pad
    input  logic [1:0]  s_tuser,  // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,  // store_byte
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int ADDR_W = pftr_pkg::ADDR_W;

    // Operation codes.
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_PIXEL = 2'd1;
    localparam logic [1:0] OP_GLYPH = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // Register indexes.
    localparam logic REG_PANEL_WIDTH  = 1'b0;
    localparam logic REG_PANEL_HEIGHT = 1'b1;

    // Sequencer states.
    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_PIX_RD   = 3'd2;
    localparam logic [2:0] S_PIX_WR   = 3'd3;
    localparam logic [2:0] S_READ     = 3'd4;
    localparam logic [2:0] S_READ_OUT = 3'd5;

    localparam logic [2:0] LAST_COL = 3'(pftr_pkg::GLYPH_COLS - 1);
    localparam logic [2:0] LAST_ROW = 3'(pftr_pkg::GLYPH_ROWS - 1);
    localparam logic [ADDR_W-1:0] LAST_BYTE = ADDR_W'(pftr_pkg::STORE_BYTES - 1);

    logic [2:0]        state_reg, state_next;
    logic [ADDR_W-1:0] sweep_reg, sweep_next;
    logic [2:0]        col_reg, col_next;
    logic [2:0]        row_reg, row_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [7:0]        m_tdata_reg;

    logic [7:0]        panel_width_reg;
    logic [6:0]        panel_height_reg;

    // Latched request fields.
    logic [1:0]        op_reg;
    logic [7:0]        x_reg;
    logic [7:0]        y_reg;
    logic              on_reg;
    logic [6:0]        gidx_reg;
    logic [9:0]        raddr_reg;

    // Pixel result held between the read and the write of the store.
    logic              hit_reg;
    logic [ADDR_W-1:0] waddr_reg;
    logic [2:0]        wbit_reg;
    logic              won_reg;

    logic              accept;
    logic              out_load;
    logic [7:0]        in_code;
    logic [6:0]        in_gidx;
    logic [7:0]        px;
    logic [7:0]        py;
    logic [7:0]        font_col;
    logic              pix_value;
    logic              read_hit;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;

    pftr_pkg::pix_t       pix;
    pftr_pkg::store_cmd_t store_cmd;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Codes outside the printable range draw as the fallback character.
    assign in_code = s_tdata[24:17];
    assign in_gidx = ((32'(in_code) < pftr_pkg::FIRST_CODE) || (32'(in_code) > pftr_pkg::LAST_CODE)) ?
                     7'(pftr_pkg::FALLBACK_CODE - pftr_pkg::FIRST_CODE) :
                     7'(in_code - 8'(pftr_pkg::FIRST_CODE));

    // Glyph coordinates wrap at eight bits before clipping.
    always_comb
    begin
        font_col = pftr_pkg::font_column(gidx_reg, col_reg);
        if (op_reg == OP_GLYPH)
        begin
            px        = x_reg + 8'(col_reg);
            py        = y_reg + 8'(row_reg);
            pix_value = font_col[row_reg];
        end
        else
        begin
            px        = x_reg;
            py        = y_reg;
            pix_value = on_reg;
        end
    end

    pftr_pixel_unit u_pixel (
        .x            (px),
        .y            (py),
        .panel_width  (panel_width_reg),
        .panel_height (panel_height_reg),
        .pix          (pix)
    );

    // A read beyond the store returns zero.
    assign read_hit = (32'(raddr_reg) < pftr_pkg::STORE_BYTES);

    always_comb
    begin
        rd_en   = ((state_reg == S_PIX_RD) && pix.hit) || ((state_reg == S_READ) && read_hit);
        rd_addr = (state_reg == S_PIX_RD) ? pix.addr : ADDR_W'(raddr_reg);

        store_cmd.wr_en   = 1'b0;
        store_cmd.clear   = 1'b0;
        store_cmd.addr    = waddr_reg;
        store_cmd.bit_sel = wbit_reg;
        store_cmd.on      = won_reg;
        if (state_reg == S_CLEAR)
        begin
            store_cmd.wr_en = 1'b1;
            store_cmd.clear = 1'b1;
            store_cmd.addr  = sweep_reg;
        end
        else if (state_reg == S_PIX_WR)
        begin
            store_cmd.wr_en = hit_reg;
        end
    end

    pftr_store u_store (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .cmd     (store_cmd),
        .rd_data (rd_data)
    );

    // Request sequencer.
    always_comb
    begin
        state_next    = state_reg;
        sweep_next    = sweep_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        out_load      = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                sweep_next = sweep_reg + ADDR_W'(1);
                if (sweep_reg == LAST_BYTE)
                begin
                    sweep_next = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    col_next = 3'd0;
                    row_next = 3'd0;
                    unique case (s_tuser)
                        OP_CLEAR: state_next = S_CLEAR;
                        OP_PIXEL: state_next = S_PIX_RD;
                        OP_GLYPH: state_next = S_PIX_RD;
                        OP_READ:  state_next = S_READ;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_PIX_RD:
            begin
                state_next = S_PIX_WR;
            end
            S_PIX_WR:
            begin
                state_next = S_IDLE;
                if ((op_reg == OP_GLYPH) && !((col_reg == LAST_COL) && (row_reg == LAST_ROW)))
                begin
                    state_next = S_PIX_RD;
                    if (row_reg == LAST_ROW)
                    begin
                        row_next = 3'd0;
                        col_next = col_reg + 3'd1;
                    end
                    else
                    begin
                        row_next = row_reg + 3'd1;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_READ_OUT;
            end
            S_READ_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    // Control state; reset starts the clearing sweep.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            sweep_reg    <= '0;
            col_reg      <= 3'd0;
            row_reg      <= 3'd0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            sweep_reg    <= sweep_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            panel_width_reg  <= 8'd128;
            panel_height_reg <= 7'd64;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PANEL_WIDTH:  panel_width_reg  <= cfg_data;
                REG_PANEL_HEIGHT: panel_height_reg <= cfg_data[6:0];
                default:          panel_width_reg  <= panel_width_reg;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= s_tuser;
            x_reg     <= s_tdata[7:0];
            y_reg     <= s_tdata[15:8];
            on_reg    <= s_tdata[16];
            gidx_reg  <= in_gidx;
            raddr_reg <= s_tdata[34:25];
        end
        if (state_reg == S_PIX_RD)
        begin
            hit_reg   <= pix.hit;
            waddr_reg <= pix.addr;
            wbit_reg  <= pix.bit_sel;
            won_reg   <= pix_value;
        end
        if (out_load)
        begin
            m_tdata_reg <= read_hit ? rd_data : 8'h00;
        end
    end

    // An accepted request always starts work.
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg != S_IDLE))
        else $error("accepted request did not leave idle");

    // A response only appears after a store read has completed.
    a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_READ_OUT))
        else $error("response raised outside a read");

    // The store is written only by the sweep or the pixel write step.
    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        store_cmd.wr_en |-> ((state_reg == S_PIX_WR) || (state_reg == S_CLEAR)))
        else $error("store written outside a write step");

    // The glyph column counter stays inside the glyph.
    a_glyph_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PIX_RD) |-> (col_reg <= LAST_COL))
        else $error("glyph column out of range");

endmodule

[sv/pftr_pixel_unit.sv]
// Shared pixel address unit: clipping against the panel size and byte address computation.
module pftr_pixel_unit (
    input  logic [7:0]          x,
    input  logic [7:0]          y,
    input  logic [7:0]          panel_width,
    input  logic [6:0]          panel_height,
    output pftr_pkg::pix_t      pix
);

    logic [pftr_pkg::COL_W-1:0]  w_eff;
    logic [pftr_pkg::ROW_W-1:0]  h_eff;
    logic [pftr_pkg::PROD_W-1:0] prod;
    logic [pftr_pkg::SUM_W-1:0]  sum;
    logic                        clip;

    always_comb
    begin
        // The active area never exceeds the store.
        w_eff = (32'(panel_width) < 32'(pftr_pkg::MAX_COLUMNS)) ?
                pftr_pkg::COL_W'(panel_width) : pftr_pkg::COL_W'(pftr_pkg::MAX_COLUMNS);
        h_eff = (32'(panel_height) < 32'(pftr_pkg::PANEL_ROWS)) ?
                pftr_pkg::ROW_W'(panel_height) : pftr_pkg::ROW_W'(pftr_pkg::PANEL_ROWS);
        clip  = (32'(x) >= 32'(w_eff)) || (32'(y) >= 32'(h_eff));
        prod  = pftr_pkg::PROD_W'(y[7:3]) * pftr_pkg::PROD_W'(w_eff);
        sum   = pftr_pkg::SUM_W'(prod) + pftr_pkg::SUM_W'(x);
        pix.hit     = !clip && (32'(sum) < 32'(pftr_pkg::STORE_BYTES));
        pix.addr    = sum[pftr_pkg::ADDR_W-1:0];
        pix.bit_sel = y[2:0];
    end

endmodule

[sv/pftr_store.sv]
// Frame store memory with a registered read port and a bit merge on write.
module pftr_store (
    input  logic                        clk,
    input  logic                        rd_en,
    input  logic [pftr_pkg::ADDR_W-1:0] rd_addr,
    input  pftr_pkg::store_cmd_t        cmd,
    output logic [7:0]                  rd_data
);

    logic [7:0] mem [pftr_pkg::STORE_BYTES];
    logic [7:0] rd_data_reg;
    logic [7:0] mask;
    logic [7:0] wr_byte;

    // The byte to modify is the one last read into rd_data_reg.
    always_comb
    begin
        mask = 8'(1) << cmd.bit_sel;
        if (cmd.clear)
        begin
            wr_byte = 8'h00;
        end
        else if (cmd.on)
        begin
            wr_byte = rd_data_reg | mask;
        end
        else
        begin
            wr_byte = rd_data_reg & ~mask;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.addr] <= wr_byte;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[tb/tb_pftr_pkg.sv]
// Operation codes, register indexes and the request layout shared by the testbench files.
`timescale 1ns / 1ps
package tb_pftr_pkg;

    // Operation carried in s_tuser.
    typedef enum logic [1:0] {
        OP_CLEAR_ALL  = 2'd0,
        OP_DRAW_PIXEL = 2'd1,
        OP_DRAW_GLYPH = 2'd2,
        OP_READ_BYTE  = 2'd3
    } op_t;

    // Configuration register indexes.
    localparam logic REG_PANEL_WIDTH  = 1'b0;
    localparam logic REG_PANEL_HEIGHT = 1'b1;

    // Operands carried in s_tdata, last field (pos_x) in the lowest bits.
    typedef struct packed {
        logic [4:0] pad;
        logic [9:0] read_address;
        logic [7:0] glyph_code;
        logic       pixel_on;
        logic [7:0] pos_y;
        logic [7:0] pos_x;
    } request_fields_t;

endpackage

[tb/tb_frame_store_mirror.sv]
// Mirror of the frame store that predicts every read byte response and compares it.
`timescale 1ns / 1ps
module tb_frame_store_mirror (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    output int          mismatch_count,
    output int          reads_outstanding
);

    logic [7:0] frame_image [pftr_pkg::STORE_BYTES];
    logic [7:0] width_reg;
    logic [6:0] height_reg;
    logic [7:0] read_bytes_due [$];
    int         fail_tally;

    // Five font columns packed with column 0 in the low byte; bit 0 is the top row.
    function automatic logic [39:0] glyph_bitmap(input int idx);
        logic [39:0] bits;
        case (idx)
            0:       bits = 40'h00_00_00_00_00;
            1:       bits = 40'h00_00_5F_00_00;
            2:       bits = 40'h00_07_00_07_00;
            3:       bits = 40'h14_7F_14_7F_14;
            4:       bits = 40'h12_2A_7F_2A_24;
            5:       bits = 40'h62_64_08_13_23;
            6:       bits = 40'h50_22_55_49_36;
            7:       bits = 40'h00_00_03_05_00;
            8:       bits = 40'h00_41_22_1C_00;
            9:       bits = 40'h00_1C_22_41_00;
            10:      bits = 40'h14_08_3E_08_14;
            11:      bits = 40'h08_08_3E_08_08;
            12:      bits = 40'h00_00_30_50_00;
            13:      bits = 40'h08_08_08_08_08;
            14:      bits = 40'h00_00_60_60_00;
            15:      bits = 40'h02_04_08_10_20;
            16:      bits = 40'h3E_45_49_51_3E;
            17:      bits = 40'h00_40_7F_42_00;
            18:      bits = 40'h46_49_51_61_42;
            19:      bits = 40'h31_4B_45_41_21;
            20:      bits = 40'h10_7F_12_14_18;
            21:      bits = 40'h39_45_45_45_27;
            22:      bits = 40'h30_49_49_4A_3C;
            23:      bits = 40'h03_05_09_71_01;
            24:      bits = 40'h36_49_49_49_36;
            25:      bits = 40'h1E_29_49_49_06;
            default: bits = 40'h00_00_00_00_00;
        endcase
        return bits;
    endfunction

    function automatic void plot_pixel(input logic [7:0] x, input logic [7:0] y,
                                       input logic lit);
        int aw;
        int ah;
        int a;
        aw = (int'(width_reg) < pftr_pkg::MAX_COLUMNS) ? int'(width_reg) :
             pftr_pkg::MAX_COLUMNS;
        ah = (int'(height_reg) < pftr_pkg::PANEL_ROWS) ? int'(height_reg) :
             pftr_pkg::PANEL_ROWS;
        if (int'(x) >= aw || int'(y) >= ah)
        begin
            return;
        end
        a = int'(x) + int'(y[7:3]) * aw;
        if (a >= pftr_pkg::STORE_BYTES)
        begin
            return;
        end
        frame_image[a][y[2:0]] = lit;
    endfunction

    // Every font bit is written, so cleared bits erase what was under the glyph.
    function automatic void draw_glyph(input logic [7:0] x, input logic [7:0] y,
                                       input logic [7:0] code);
        int          c;
        logic [39:0] bitmap;
        logic [7:0]  column;
        c = int'(code);
        if (c < pftr_pkg::FIRST_CODE || c > pftr_pkg::LAST_CODE)
        begin
            c = pftr_pkg::FALLBACK_CODE;
        end
        bitmap = glyph_bitmap(c - pftr_pkg::FIRST_CODE);
        for (int i = 0; i < pftr_pkg::GLYPH_COLS; i++)
        begin
            column = bitmap[8*i +: 8];
            for (int j = 0; j < pftr_pkg::GLYPH_ROWS; j++)
            begin
                plot_pixel(x + 8'(i), y + 8'(j), column[j]);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        tb_pftr_pkg::request_fields_t req;
        logic [7:0]                   due;
        if (!rst_n)
        begin
            for (int a = 0; a < pftr_pkg::STORE_BYTES; a++)
            begin
                frame_image[a] = 8'h00;
            end
            width_reg  = 8'd128;
            height_reg = 7'd64;
            read_bytes_due.delete();
            fail_tally = 0;
            mismatch_count    <= 0;
            reads_outstanding <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (read_bytes_due.size() == 0)
                begin
                    $error("store_byte: no read pending, actual %02h", m_tdata);
                    fail_tally++;
                end
                else
                begin
                    due = read_bytes_due.pop_front();
                    if (m_tdata !== due)
                    begin
                        $error("store_byte mismatch: expected %02h, actual %02h", due, m_tdata);
                        fail_tally++;
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == tb_pftr_pkg::REG_PANEL_WIDTH)
                begin
                    width_reg = cfg_data;
                end
                else if (cfg_index == tb_pftr_pkg::REG_PANEL_HEIGHT)
                begin
                    height_reg = cfg_data[6:0];
                end
            end
            if (s_tvalid && s_tready)
            begin
                req = s_tdata;
                case (tb_pftr_pkg::op_t'(s_tuser))
                    tb_pftr_pkg::OP_CLEAR_ALL:
                    begin
                        for (int a = 0; a < pftr_pkg::STORE_BYTES; a++)
                        begin
                            frame_image[a] = 8'h00;
                        end
                    end
                    tb_pftr_pkg::OP_DRAW_PIXEL:
                    begin
                        plot_pixel(req.pos_x, req.pos_y, req.pixel_on);
                    end
                    tb_pftr_pkg::OP_DRAW_GLYPH:
                    begin
                        draw_glyph(req.pos_x, req.pos_y, req.glyph_code);
                    end
                    default:
                    begin
                        if (int'(req.read_address) < pftr_pkg::STORE_BYTES)
                        begin
                            read_bytes_due.push_back(frame_image[req.read_address]);
                        end
                        else
                        begin
                            read_bytes_due.push_back(8'h00);
                        end
                    end
                endcase
            end
            mismatch_count    <= fail_tally;
            reads_outstanding <= read_bytes_due.size();
        end
    end

endmodule

[tb/tb_page_framebuffer_text_renderer.sv]
// Top of the frame buffer text renderer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_page_framebuffer_text_renderer;

    // The longest request is a clear all, which sweeps the whole store. The pause before
    // a register write and at the end covers that sweep with margin.
    localparam int DRAIN_CYCLES    = 1100;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int HOLD_OFF_CYCLES = 500;
    localparam int PHASE_COUNT     = 6;
    localparam int ITEMS_PER_PHASE = 88;
    localparam int RANDOM_ITEMS    = PHASE_COUNT * ITEMS_PER_PHASE;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = tb_pftr_pkg::OP_CLEAR_ALL;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = tb_pftr_pkg::REG_PANEL_WIDTH;
    logic [7:0]  cfg_data  = 8'd0;

    int mismatch_count;
    int reads_outstanding;
    int cycle_count     = 0;
    int tx_idle_pct     = 28;
    int rx_idle_pct     = 74;
    bit hold_off_wanted = 1'b0;

    // The panel size as last written, so that random requests can aim at the active area.
    int cur_width  = 128;
    int cur_height = 64;

    page_framebuffer_text_renderer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tb_frame_store_mirror store_mirror (
        .clk               (clk),
        .rst_n             (rst_n),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .s_tuser           (s_tuser),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .mismatch_count    (mismatch_count),
        .reads_outstanding (reads_outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Response side. It stalls at random, and once, when the stimulus asks for it, it
    // holds off for a long stretch so that the output register stays full and a
    // following read request backs up into the input.
    initial
    begin : response_sink
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_wanted && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Offer one request and return at the edge where it is taken. Idle cycles come
    // first, with s_tvalid low; s_tvalid is only assigned once per clock edge.
    task automatic send_request(input tb_pftr_pkg::op_t op, input logic [7:0] x,
                                input logic [7:0] y, input logic on,
                                input logic [7:0] code, input logic [9:0] addr);
        tb_pftr_pkg::request_fields_t f;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        f.pad          = '0;
        f.read_address = addr;
        f.glyph_code   = code;
        f.pixel_on     = on;
        f.pos_y        = y;
        f.pos_x        = x;
        s_tdata  <= f;
        s_tuser  <= op;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
    endtask

    // Drop s_tvalid, wait for every read response, then let a possible clear sweep
    // or glyph finish, since those leave no response to wait for.
    task automatic wait_until_idle();
        s_tvalid <= 1'b0;
        while (reads_outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic index, input logic [7:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // The height register is seven bits wide, so the top bit of its write data is dropped.
    task automatic set_panel(input logic [7:0] width_value, input logic [7:0] height_value);
        write_register(tb_pftr_pkg::REG_PANEL_WIDTH, width_value);
        write_register(tb_pftr_pkg::REG_PANEL_HEIGHT, height_value);
        cur_width  = int'(width_value);
        cur_height = int'(height_value[6:0]);
    endtask

    // Idle profile by position in the random part: sender light and receiver heavy,
    // then the reverse, then a final stretch with no idling on either side.
    task automatic set_idle_profile(input int item_index);
        if (item_index < RANDOM_ITEMS / 3)
        begin
            tx_idle_pct = 28;
            rx_idle_pct = 74;
        end
        else if (item_index < 2 * RANDOM_ITEMS / 3)
        begin
            tx_idle_pct = 74;
            rx_idle_pct = 28;
        end
        else
        begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    endtask

    // Most requests, if the active area is not empty, aim at it, including its
    // first two clipped columns and rows, so that drawn pixels are later seen
    // by reads. The rest carry fully random operands, which also covers glyph
    // coordinate wrap. Unused operands always carry noise.
    task automatic send_random_request();
        int               roll;
        int               aw;
        int               ah;
        int               page;
        bit               aimed;
        tb_pftr_pkg::op_t op;
        logic [7:0]       x;
        logic [7:0]       y;
        logic             on;
        logic [7:0]       code;
        logic [9:0]       addr;
        aw    = (cur_width < pftr_pkg::MAX_COLUMNS) ? cur_width : pftr_pkg::MAX_COLUMNS;
        ah    = (cur_height < pftr_pkg::PANEL_ROWS) ? cur_height : pftr_pkg::PANEL_ROWS;
        aimed = (aw > 0) && (ah > 0) && ($urandom_range(0, 9) < 8);
        x     = 8'($urandom);
        y     = 8'($urandom);
        on    = 1'($urandom);
        code  = 8'($urandom);
        addr  = 10'($urandom);
        roll  = $urandom_range(0, 99);
        if (roll < 2)
        begin
            op = tb_pftr_pkg::OP_CLEAR_ALL;
        end
        else if (roll < 36)
        begin
            op = tb_pftr_pkg::OP_DRAW_PIXEL;
            if (aimed)
            begin
                x = 8'($urandom_range(0, aw + 1));
                y = 8'($urandom_range(0, ah + 1));
            end
        end
        else if (roll < 60)
        begin
            op = tb_pftr_pkg::OP_DRAW_GLYPH;
            if ($urandom_range(0, 9) < 8)
            begin
                code = 8'($urandom_range(pftr_pkg::FIRST_CODE,
                                         pftr_pkg::FIRST_CODE + pftr_pkg::ROM_GLYPHS - 1));
            end
            if (aimed)
            begin
                x = 8'($urandom_range(0, aw + 1));
                y = 8'($urandom_range(0, ah + 1));
            end
        end
        else
        begin
            op = tb_pftr_pkg::OP_READ_BYTE;
            if (aimed)
            begin
                page = $urandom_range(0, (ah - 1) / 8);
                addr = 10'(page * aw + $urandom_range(0, aw - 1));
            end
        end
        send_request(op, x, y, on, code, addr);
    endtask

    initial
    begin : stimulus
        int item_index;
        logic [7:0] width_value;
        logic [7:0] height_value;
        item_index = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, at the panel size that reset leaves. The store starts cleared.
        send_request(tb_pftr_pkg::OP_READ_BYTE, 8'd0, 8'd0, 1'b0, 8'd0, 10'd0);
        send_request(tb_pftr_pkg::OP_READ_BYTE, 8'd0, 8'd0, 1'b0, 8'd0, 10'd1023);
        // Corner pixels of the panel, top left and bottom right.
        send_request(tb_pftr_pkg::OP_DRAW_PIXEL, 8'd0, 8'd0, 1'b1, 8'd0, 10'd0);
        send_request(tb_pftr_pkg::OP_READ_BYTE, 8'd0, 8'd0, 1'b0, 8'd0, 10'd0);
        send_request(tb_pftr_pkg::OP_DRAW_PIXEL, 8'd127, 8'd63, 1'b1, 8'd0, 10'd0);
        send_request(tb_pftr_pkg::OP_READ_BYTE, 8'd0, 8'd0, 1'b0, 8'd0, 10'd1023);
        // Pixels just past the active width and height and at the field maxima are clipped.
        send_request(tb_pftr_pkg::OP_DRAW_PIXEL, 8'd128, 8'd0, 1'b1, 8'd0, 10'd0);
        send_request(tb_pftr_pkg::OP_DRAW_PIXEL, 8'd0, 8'd64, 1'b1, 8'd0, 10'd0);
        send_request(tb_pftr_pkg::OP_DRAW_PIXEL, 8'd255, 8'd255, 1'b1, 8'd0, 10'd0);
        send_request(tb_pftr_pkg::OP_READ_BYTE, 8'd0, 8'd0, 1'b0, 8'd0, 10'd128);
        // Clearing a lit pixel.
        send_request(tb_pftr_pkg::OP_DRAW_PIXEL, 8'd0, 8'd0, 1'b0, 8'd0, 10'd0);
        send_request(tb_pftr_pkg::OP_READ_BYTE, 8'd0, 8'd0, 1'b0, 8'd0, 10'd0);
        // A digit on page 0, then a glyph that straddles pages 0 and 1.
        send_request(tb_pftr_pkg::OP_DRAW_GLYPH, 8'd10, 8'd0, 1'b0, 8'd48, 10'd0);
        send_request(tb_pftr_pkg::OP_READ_BYTE, 8'd0, 8'd0, 1'b0, 8'd0, 10'd11);
        send_request(tb_pftr_pkg::OP_DRAW_GLYPH, 8'd20, 8'd4, 1'b0, 8'd35, 10'd0);
        send_request(tb_pftr_pkg::OP_READ_BYTE, 8'd0, 8'd0, 1'b0, 8'd0, 10'd20);
        send_request(tb_pftr_pkg::OP_READ_BYTE, 8'd0, 8'd0, 1'b0, 8'd0, 10'd148);
        // An unprintable code draws the blank fallback glyph and erases the digit.
        send_request(tb_pftr_pkg::OP_DRAW_GLYPH, 8'd10, 8'd0, 1'b0, 8'd0, 10'd0);
        send_request(tb_pftr_pkg::OP_READ_BYTE, 8'd0, 8'd0, 1'b0, 8'd0, 10'd11);
        // Codes above 127, the last printable code and a letter past the font all blank.
        send_request(tb_pftr_pkg::OP_DRAW_GLYPH, 8'd20, 8'd4, 1'b0, 8'd255, 10'd0);
        send_request(tb_pftr_pkg::OP_DRAW_GLYPH, 8'd30, 8'd8, 1'b0, 8'd127, 10'd0);
        send_request(tb_pftr_pkg::OP_DRAW_GLYPH, 8'd40, 8'd8, 1'b0, 8'd65, 10'd0);
        // Glyph coordinates wrap at 8 bits: the lower right part lands in the top left corner.
        send_request(tb_pftr_pkg::OP_DRAW_GLYPH, 8'd254, 8'd254, 1'b0, 8'd56, 10'd0);
        send_request(tb_pftr_pkg::OP_READ_BYTE, 8'd0, 8'd0, 1'b0, 8'd0, 10'd1);
        // Clear all, then a read of a byte that held glyph pixels.
        send_request(tb_pftr_pkg::OP_CLEAR_ALL, 8'd0, 8'd0, 1'b0, 8'd0, 10'd0);
        send_request(tb_pftr_pkg::OP_READ_BYTE, 8'd0, 8'd0, 1'b0, 8'd0, 10'd148);

        // Random part, one panel size per phase. The sizes cover the full panel, width
        // and height above the store, zero width, a single pixel, zero height and a
        // random size. Registers are only written once the block has gone idle.
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0:
                begin
                    width_value  = 8'd128;
                    height_value = 8'd64;
                end
                1:
                begin
                    width_value  = 8'd255;
                    height_value = 8'hFF;
                end
                2:
                begin
                    width_value  = 8'd0;
                    height_value = 8'd40;
                end
                3:
                begin
                    width_value  = 8'd1;
                    height_value = 8'd1;
                end
                4:
                begin
                    width_value  = 8'd90;
                    height_value = 8'd0;
                end
                default:
                begin
                    width_value  = 8'($urandom_range(1, pftr_pkg::MAX_COLUMNS));
                    height_value = 8'($urandom_range(1, pftr_pkg::PANEL_ROWS));
                end
            endcase
            wait_until_idle();
            set_panel(width_value, height_value);
            // The long receiver hold-off falls at the start of the random part.
            if (phase == 0)
            begin
                hold_off_wanted = 1'b1;
            end
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                set_idle_profile(item_index);
                send_random_request();
                item_index++;
            end
        end

        wait_until_idle();
        if (mismatch_count == 0 && reads_outstanding == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
